// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold prop on every clock edge
`define LST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// require cons in the cycle after ante
`define LST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lst_pkg.sv =====
// ---------------------------------------------------------------------------
// lst_pkg
// Shared sizes, operation and status codes, sequencer states and memory
// request types of the sequential list engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lst_pkg;

  localparam int DEPTH  = 256;
  localparam int WIDTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KIND_W = 3;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_BACK  = 3'd0,
    K_PUSH_FRONT = 3'd1,
    K_POP_BACK   = 3'd2,
    K_POP_FRONT  = 3'd3,
    K_INSERT     = 3'd4,
    K_ERASE      = 3'd5,
    K_FIND       = 3'd6,
    K_MODIFY     = 3'd7
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    S_OK     = 2'd0,
    S_FULL   = 2'd1,
    S_EMPTY  = 2'd2,
    S_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_FIND
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WIDTH-1:0]  wdata;
  } wr_req_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } rd_req_t;

endpackage

// ===== hdl/lst_in_if.sv =====
// ---------------------------------------------------------------------------
// lst_in_if
// Request channel: operation kind, position and value with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lst_in_if;
  import lst_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  position;
  logic [WIDTH-1:0]  value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

// ===== hdl/lst_out_if.sv =====
// ---------------------------------------------------------------------------
// lst_out_if
// Result channel: status, find index and flag, and count with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lst_out_if;
  import lst_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  found_index;
  logic              found;
  logic [CNT_W-1:0]  count;

  modport source (output valid, output status, output found_index, output found,
                  output count, input ready);
  modport sink   (input valid, input status, input found_index, input found,
                  input count, output ready);
endinterface

// ===== hdl/lst_ram.sv =====
// ---------------------------------------------------------------------------
// lst_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lst_ram #(
  parameter int DEPTH_P = 256,
  parameter int WIDTH_P = 32,
  parameter int ADDR_P  = $clog2(DEPTH_P)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_P-1:0]  waddr,
  input  logic [WIDTH_P-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_P-1:0]  raddr,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/lst_ctrl.sv =====
// ---------------------------------------------------------------------------
// lst_ctrl
// Operation decoder and memory walker: checks full, empty and position,
// steps shifts and searches one entry per cycle, holds the result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lst_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  lst_in_if.sink                 in_ch,
  lst_out_if.source              out_ch,
  output lst_pkg::wr_req_t       wr,
  output lst_pkg::rd_req_t       rd,
  input  logic [lst_pkg::WIDTH-1:0] rdata
);
  import lst_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   ra_r, ra_nxt;
  logic [ADDR_W-1:0]   lim_r, lim_nxt;
  logic [ADDR_W-1:0]   wa_r, wa_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [WIDTH-1:0]    val_r, val_nxt;
  logic                issue_r, issue_nxt;
  logic                rdv_r, rdv_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [POS_W-1:0]    out_fidx_r, out_fidx_nxt;
  logic                out_found_r, out_found_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;

  logic                in_fire;
  logic                is_full, is_empty, bad_pos, pos_last;
  logic [CNT_W-1:0]    pos_c;
  logic [ADDR_W-1:0]   last_a;
  logic                start_up, start_dn, load;
  logic [ADDR_W-1:0]   start_pos;
  status_t             res_status;
  logic                res_found;
  logic [ADDR_W-1:0]   res_fidx;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign pos_c    = CNT_W'(in_ch.position);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign bad_pos  = (pos_c >= count_r);
  assign last_a   = ADDR_W'(count_r - CNT_W'(1));
  assign pos_last = (pos_c == count_r - CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ra_nxt        = ra_r;
    lim_nxt       = lim_r;
    wa_nxt        = wa_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    issue_nxt     = issue_r;
    rdv_nxt       = 1'b0;
    wr            = '0;
    rd            = '0;
    start_up      = 1'b0;
    start_dn      = 1'b0;
    start_pos     = ADDR_W'(in_ch.position);
    load          = 1'b0;
    res_status    = S_OK;
    res_found     = 1'b0;
    res_fidx      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (kind_t'(in_ch.kind))
            K_PUSH_BACK: begin
              load = 1'b1;
              if (is_full) begin
                res_status = S_FULL;
              end else begin
                wr.we     = 1'b1;
                wr.waddr  = ADDR_W'(count_r);
                wr.wdata  = in_ch.value;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            K_PUSH_FRONT: begin
              start_pos = '0;
              if (is_full) begin
                load       = 1'b1;
                res_status = S_FULL;
              end else if (is_empty) begin
                load      = 1'b1;
                wr.we     = 1'b1;
                wr.waddr  = '0;
                wr.wdata  = in_ch.value;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                start_up = 1'b1;
              end
            end
            K_POP_BACK: begin
              load = 1'b1;
              if (is_empty) begin
                res_status = S_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            K_POP_FRONT: begin
              start_pos = '0;
              if (is_empty) begin
                load       = 1'b1;
                res_status = S_EMPTY;
              end else if (count_r == CNT_W'(1)) begin
                load      = 1'b1;
                count_nxt = count_r - CNT_W'(1);
              end else begin
                start_dn = 1'b1;
              end
            end
            K_INSERT: begin
              if (is_full) begin
                load       = 1'b1;
                res_status = S_FULL;
              end else if (bad_pos) begin
                load       = 1'b1;
                res_status = S_BADPOS;
              end else begin
                start_up = 1'b1;
              end
            end
            K_ERASE: begin
              if (is_empty) begin
                load       = 1'b1;
                res_status = S_EMPTY;
              end else if (bad_pos) begin
                load       = 1'b1;
                res_status = S_BADPOS;
              end else if (pos_last) begin
                load      = 1'b1;
                count_nxt = count_r - CNT_W'(1);
              end else begin
                start_dn = 1'b1;
              end
            end
            K_FIND: begin
              if (is_empty) begin
                load = 1'b1;
              end else begin
                state_nxt = ST_FIND;
                ra_nxt    = '0;
                lim_nxt   = last_a;
                val_nxt   = in_ch.value;
                issue_nxt = 1'b1;
              end
            end
            K_MODIFY: begin
              load = 1'b1;
              if (bad_pos) begin
                res_status = S_BADPOS;
              end else begin
                wr.we    = 1'b1;
                wr.waddr = ADDR_W'(in_ch.position);
                wr.wdata = in_ch.value;
              end
            end
          endcase

          if (start_up) begin
            state_nxt = ST_SHIFT_UP;
            ra_nxt    = last_a;
            lim_nxt   = start_pos;
            pos_nxt   = start_pos;
            val_nxt   = in_ch.value;
            issue_nxt = 1'b1;
          end
          if (start_dn) begin
            state_nxt = ST_SHIFT_DN;
            ra_nxt    = start_pos + ADDR_W'(1);
            lim_nxt   = last_a;
            issue_nxt = 1'b1;
          end
        end
      end

      ST_SHIFT_UP: begin
        rd.re    = issue_r;
        rd.raddr = ra_r;
        if (issue_r) begin
          rdv_nxt = 1'b1;
          wa_nxt  = ra_r + ADDR_W'(1);
          if (ra_r == lim_r) begin
            issue_nxt = 1'b0;
          end else begin
            ra_nxt = ra_r - ADDR_W'(1);
          end
        end
        if (rdv_r) begin
          wr.we    = 1'b1;
          wr.waddr = wa_r;
          wr.wdata = rdata;
        end else if (!issue_r) begin
          wr.we     = 1'b1;
          wr.waddr  = pos_r;
          wr.wdata  = val_r;
          count_nxt = count_r + CNT_W'(1);
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_SHIFT_DN: begin
        rd.re    = issue_r;
        rd.raddr = ra_r;
        if (issue_r) begin
          rdv_nxt = 1'b1;
          wa_nxt  = ra_r - ADDR_W'(1);
          if (ra_r == lim_r) begin
            issue_nxt = 1'b0;
          end else begin
            ra_nxt = ra_r + ADDR_W'(1);
          end
        end
        if (rdv_r) begin
          wr.we    = 1'b1;
          wr.waddr = wa_r;
          wr.wdata = rdata;
        end else if (!issue_r) begin
          count_nxt = count_r - CNT_W'(1);
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_FIND: begin
        rd.re    = issue_r;
        rd.raddr = ra_r;
        if (issue_r) begin
          rdv_nxt = 1'b1;
          wa_nxt  = ra_r;
          if (ra_r == lim_r) begin
            issue_nxt = 1'b0;
          end else begin
            ra_nxt = ra_r + ADDR_W'(1);
          end
        end
        priority if (rdv_r && (rdata == val_r)) begin
          load      = 1'b1;
          res_found = 1'b1;
          res_fidx  = wa_r;
          issue_nxt = 1'b0;
          rdv_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else if (!issue_r && !rdv_r) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          load = 1'b0;
        end
      end
    endcase

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_fidx_nxt   = out_fidx_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_fidx_nxt   = POS_W'(res_fidx);
      out_found_nxt  = res_found;
      out_count_nxt  = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issue_r     <= 1'b0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r         <= ra_nxt;
    lim_r        <= lim_nxt;
    wa_r         <= wa_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_fidx_r   <= out_fidx_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_fidx_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.count       = out_count_r;

  `LST_ASSERT(a_count_cap, count_r <= CNT_W'(DEPTH), "element count beyond capacity")
  `LST_ASSERT(a_rw_apart, (wr.we && rd.re) |-> (wr.waddr != rd.raddr), "read and write on one entry")
  `LST_ASSERT(a_rdv_busy, rdv_r |-> (state_r != ST_IDLE), "read data pending while idle")
  `LST_ASSERT_NEXT(a_done_word, (state_r != ST_IDLE) && (state_nxt == ST_IDLE), out_valid_r, "walk ended without result word")

endmodule

// ===== hdl/sequential_list_engine.sv =====
// Push back, pop back, modify, find on an empty list, every rejected request and
//   any request that moves no entry give their result word in the cycle after acceptance.
// Insert and push front shift entries position..last up by one and then write the value;
//   erase and pop front shift entries above position down; find scans up from index 0.
// One request is handled at a time; a walk moves over the store one entry per cycle.
// Reset clears the count and control state; the store itself is left uncleared.
// ---------------------------------------------------------------------------
// sequential_list_engine
// Fixed-capacity ordered list of signed words held in one synchronous RAM,
// with push, pop, insert, erase, find and modify requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequential_list_engine (
  input  logic      clk,
  input  logic      rst_n,
  lst_in_if.sink    in_chan,
  lst_out_if.source out_chan
);
  import lst_pkg::*;

  wr_req_t          wr;
  rd_req_t          rd;
  logic [WIDTH-1:0] rdata;

  lst_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_chan),
    .out_ch (out_chan),
    .wr     (wr),
    .rd     (rd),
    .rdata  (rdata)
  );

  lst_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.waddr),
    .wdata (wr.wdata),
    .re    (rd.re),
    .raddr (rd.raddr),
    .rdata (rdata)
  );

endmodule
